// File: hdl/csa_pkg.sv
// Shared types, codes and the saturating Q16.16 accumulate for the CSR
// assembly store. No dependencies.
`default_nettype none

package csa_pkg;

    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_INSERT = 3'd1,
        OP_ADD_M  = 3'd2,
        OP_ADD_R  = 3'd3,
        OP_READ_M = 3'd4,
        OP_READ_R = 3'd5,
        OP_CLR_M  = 3'd6,
        OP_CLR_R  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_IGNORED   = 2'd1,
        ST_NO_COLUMN = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_INS_CHK,
        S_INS_CMP,
        S_INS_PUT,
        S_FND_B,
        S_FND_E,
        S_FND_E2,
        S_SR_CHK,
        S_SR_CMP,
        S_VAL_RD,
        S_VAL_UPD,
        S_DONE
    } t_state;

    // old + floor(prod / 2^16), saturated to 32 bits
    function automatic logic signed [31:0] sat_acc(input logic signed [31:0] old,
                                                    input logic signed [63:0] prod);
        logic signed [63:0] q;
        logic signed [63:0] s;
        q = prod >>> 16;
        s = 64'(old) + q;
        if (s > 64'sh0000_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (s < -64'sh0000_0000_8000_0000)
            return 32'sh8000_0000;
        else
            return s[31:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/csa_req_if.sv
// Request channel of the CSR assembly store: valid/ready plus one operation.
// No dependencies.
`default_nettype none

interface csa_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] value;
    logic signed [31:0] scale;

    modport source(output valid, opcode, row, col, value, scale, input ready);
    modport sink(input valid, opcode, row, col, value, scale, output ready);
endinterface

`default_nettype wire

// File: hdl/csa_rsp_if.sv
// Response channel of the CSR assembly store: valid/ready, status, read data.
// No dependencies.
`default_nettype none

interface csa_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_data;

    modport source(output valid, status, read_data, input ready);
    modport sink(input valid, status, read_data, output ready);
endinterface

`default_nettype wire

// File: hdl/csa_cfg_if.sv
// Configuration write channel: valid/ready and the num_equations value.
// No dependencies.
`default_nettype none

interface csa_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// File: hdl/csr_sparse_assembly_store.sv
// CSR sparse matrix and rhs store for finite element assembly: structure
// build, scaled accumulate, read and clear. Uses csa_pkg and the three
// channel interfaces.
//
// One request at a time under a small sequencer around single-port memories
// (row ends, column indices, matrix values, rhs values) and one multiplier.
// Start row is done at decode, an rhs add/read reads then updates the value.
// Insert steps once per column it moves past; a matrix add/read steps once
// per column searched in the row. A clear of the matrix sweeps the filled
// entries one a cycle while the sequencer is idle or done; a clear of the rhs
// sweeps num_equations entries; a num_equations write sweeps both (max of
// filled entries and the new row count). The request side is not ready
// during a sweep. The result sits in an output register, so it may wait while
// the next request is taken.
`default_nettype none

module csr_sparse_assembly_store
    import csa_pkg::*;
#(
    parameter int MAX_EQUATIONS = 256,
    parameter int MAX_NONZEROS  = 4096
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    csa_req_if.sink    i_req,
    csa_rsp_if.source  o_rsp,
    csa_cfg_if.sink    i_cfg
);

    localparam int NZW = $clog2(MAX_NONZEROS);
    localparam int EQW = $clog2(MAX_EQUATIONS);
    localparam int RBW = $clog2(MAX_EQUATIONS + 1);
    localparam int CW  = ((NZW > EQW) ? NZW : EQW) + 1;
    localparam logic [8:0]   LIM_CAP = (MAX_EQUATIONS > 511) ? 9'd511 : 9'(MAX_EQUATIONS);
    localparam logic [NZW:0] NZ_FULL = (NZW + 1)'(MAX_NONZEROS);

    // memories
    logic [NZW:0]       r_rs_mem [MAX_EQUATIONS];
    logic [7:0]         r_cs_mem [MAX_NONZEROS];
    logic signed [31:0] r_mv_mem [MAX_NONZEROS];
    logic signed [31:0] r_rh_mem [MAX_EQUATIONS];
    logic [NZW:0]       r_rs_q;
    logic [7:0]         r_cs_q;
    logic signed [31:0] r_mv_q;
    logic signed [31:0] r_rh_q;

    logic [EQW-1:0]     rs_addr;
    logic               rs_we;
    logic [NZW:0]       rs_wdata;
    logic [NZW-1:0]     cs_addr;
    logic               cs_we;
    logic [7:0]         cs_wdata;
    logic [NZW-1:0]     mv_addr;
    logic               mv_we;
    logic signed [31:0] mv_wdata;
    logic [EQW-1:0]     rh_addr;
    logic               rh_we;
    logic signed [31:0] rh_wdata;

    // control and working registers
    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [7:0]         r_row, n_row;
    logic [7:0]         r_col, n_col;
    logic signed [31:0] r_value, n_value;
    logic signed [31:0] r_scale, n_scale;
    logic signed [63:0] r_prod;
    logic [NZW:0]       r_k, n_k;
    logic [NZW:0]       r_end, n_end;
    logic [NZW:0]       r_filled, n_filled;
    logic [RBW-1:0]     r_rows, n_rows;
    logic [NZW:0]       r_seg, n_seg;
    logic [8:0]         r_num_eq, n_num_eq;
    t_status            r_res_status, n_res_status;
    logic signed [31:0] r_res_data, n_res_data;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic signed [31:0] r_out_data, n_out_data;
    logic [CW-1:0]      r_clr_cnt, n_clr_cnt;
    logic [NZW:0]       r_clr_mend, n_clr_mend;
    logic [8:0]         r_clr_rend, n_clr_rend;

    logic [8:0]         lim;
    logic [8:0]         cfg_lim;
    logic               clearing;
    logic               req_take;
    logic               cfg_take;
    logic               full;

    assign lim      = (r_num_eq > LIM_CAP) ? LIM_CAP : r_num_eq;
    assign cfg_lim  = (i_cfg.data > LIM_CAP) ? LIM_CAP : i_cfg.data;
    assign clearing = (r_clr_cnt < CW'(r_clr_mend)) || (r_clr_cnt < CW'(r_clr_rend));
    assign full     = (r_filled >= NZ_FULL);

    assign i_req.ready = (r_state == S_IDLE) && !clearing;
    assign i_cfg.ready = 1'b1;
    assign req_take    = i_req.valid && i_req.ready;
    assign cfg_take    = i_cfg.valid;

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.read_data = r_out_data;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_row        = r_row;
        n_col        = r_col;
        n_value      = r_value;
        n_scale      = r_scale;
        n_k          = r_k;
        n_end        = r_end;
        n_filled     = r_filled;
        n_rows       = r_rows;
        n_seg        = r_seg;
        n_num_eq     = r_num_eq;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_clr_cnt    = r_clr_cnt;
        n_clr_mend   = r_clr_mend;
        n_clr_rend   = r_clr_rend;

        rs_addr  = EQW'(r_row);
        rs_we    = 1'b0;
        rs_wdata = r_filled + 1'b1;
        cs_addr  = NZW'(r_k);
        cs_we    = 1'b0;
        cs_wdata = r_col;
        mv_addr  = NZW'(r_k);
        mv_we    = 1'b0;
        mv_wdata = sat_acc(r_mv_q, r_prod);
        rh_addr  = EQW'(r_row);
        rh_we    = 1'b0;
        rh_wdata = sat_acc(r_rh_q, r_prod);

        if (r_out_valid && o_rsp.ready)
            n_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    n_op       = t_op'(i_req.opcode);
                    n_row      = i_req.row;
                    n_col      = i_req.col;
                    n_value    = i_req.value;
                    n_scale    = i_req.scale;
                    n_res_data = '0;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_res_status = ST_OK;
                n_state      = S_DONE;
                unique case (r_op)
                    OP_START: begin
                        if (16'(r_col) >= 16'(lim) || 16'(r_rows) >= 16'(lim)) begin
                            n_res_status = ST_IGNORED;
                        end else if (full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            cs_we    = 1'b1;
                            cs_addr  = NZW'(r_filled);
                            rs_we    = 1'b1;
                            rs_addr  = EQW'(r_rows);
                            // newly filled value slot starts at zero
                            mv_we    = 1'b1;
                            mv_addr  = NZW'(r_filled);
                            mv_wdata = '0;
                            n_seg    = r_filled;
                            n_filled = r_filled + 1'b1;
                            n_rows   = r_rows + 1'b1;
                        end
                    end
                    OP_INSERT: begin
                        if (r_rows == '0 || 16'(r_col) >= 16'(lim)) begin
                            n_res_status = ST_IGNORED;
                        end else if (full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            mv_we    = 1'b1;
                            mv_addr  = NZW'(r_filled);
                            mv_wdata = '0;
                            n_k      = r_filled;
                            n_state  = S_INS_CHK;
                        end
                    end
                    OP_ADD_M, OP_READ_M: begin
                        if ((r_op == OP_ADD_M && r_scale == '0) ||
                            16'(r_row) >= 16'(lim) || 16'(r_col) >= 16'(lim)) begin
                            n_res_status = ST_IGNORED;
                        end else if (16'(r_row) >= 16'(r_rows)) begin
                            n_res_status = ST_NO_COLUMN;
                        end else begin
                            n_state = S_FND_B;
                        end
                    end
                    OP_ADD_R, OP_READ_R: begin
                        if ((r_op == OP_ADD_R && r_scale == '0) ||
                            16'(r_row) >= 16'(lim)) begin
                            n_res_status = ST_IGNORED;
                        end else begin
                            n_state = S_VAL_RD;
                        end
                    end
                    OP_CLR_M: begin
                        n_clr_cnt  = '0;
                        n_clr_mend = r_filled;
                        n_clr_rend = '0;
                    end
                    OP_CLR_R: begin
                        n_clr_cnt  = '0;
                        n_clr_mend = '0;
                        n_clr_rend = lim;
                    end
                    default: ;
                endcase
            end
            // backward scan: move larger columns up one place
            S_INS_CHK: begin
                if (r_k > r_seg) begin
                    cs_addr = NZW'(r_k - 1'b1);
                    n_state = S_INS_CMP;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_CMP: begin
                if (r_cs_q > r_col) begin
                    cs_we    = 1'b1;
                    cs_wdata = r_cs_q;
                    n_k      = r_k - 1'b1;
                    n_state  = S_INS_CHK;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                cs_we        = 1'b1;
                rs_we        = 1'b1;
                rs_addr      = EQW'(r_rows - 1'b1);
                n_filled     = r_filled + 1'b1;
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end
            S_FND_B: begin
                rs_addr = EQW'(8'(r_row - 8'd1));
                n_state = S_FND_E;
            end
            S_FND_E: begin
                n_k     = (r_row == 8'd0) ? '0 : r_rs_q;
                n_state = S_FND_E2;
            end
            S_FND_E2: begin
                n_end   = r_rs_q;
                n_state = S_SR_CHK;
            end
            S_SR_CHK: begin
                if (r_k < r_end) begin
                    n_state = S_SR_CMP;
                end else begin
                    n_res_status = ST_NO_COLUMN;
                    n_state      = S_DONE;
                end
            end
            S_SR_CMP: begin
                if (r_cs_q == r_col) begin
                    n_state = S_VAL_RD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SR_CHK;
                end
            end
            S_VAL_RD: begin
                n_state = S_VAL_UPD;
            end
            S_VAL_UPD: begin
                case (r_op)
                    OP_ADD_M:  mv_we = 1'b1;
                    OP_ADD_R:  rh_we = 1'b1;
                    OP_READ_M: n_res_data = r_mv_q;
                    default:   n_res_data = r_rh_q;
                endcase
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = r_res_data;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // clearing sweep only runs while the sequencer leaves the memories alone
        if (clearing && (r_state == S_IDLE || r_state == S_DONE)) begin
            if (r_clr_cnt < CW'(r_clr_mend)) begin
                mv_we    = 1'b1;
                mv_addr  = NZW'(r_clr_cnt);
                mv_wdata = '0;
            end
            if (r_clr_cnt < CW'(r_clr_rend)) begin
                rh_we    = 1'b1;
                rh_addr  = EQW'(r_clr_cnt);
                rh_wdata = '0;
            end
            n_clr_cnt = r_clr_cnt + 1'b1;
        end

        if (cfg_take) begin
            n_num_eq   = i_cfg.data;
            n_filled   = '0;
            n_rows     = '0;
            n_seg      = '0;
            n_clr_cnt  = '0;
            n_clr_mend = (r_clr_mend > r_filled) ? r_clr_mend : r_filled;
            n_clr_rend = cfg_lim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filled    <= '0;
            r_rows      <= '0;
            r_seg       <= '0;
            r_num_eq    <= '0;
            r_out_valid <= 1'b0;
            r_clr_cnt   <= '0;
            r_clr_mend  <= '0;
            r_clr_rend  <= '0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_rows      <= n_rows;
            r_seg       <= n_seg;
            r_num_eq    <= n_num_eq;
            r_out_valid <= n_out_valid;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_mend  <= n_clr_mend;
            r_clr_rend  <= n_clr_rend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_row        <= n_row;
        r_col        <= n_col;
        r_value      <= n_value;
        r_scale      <= n_scale;
        r_prod       <= r_scale * r_value;
        r_k          <= n_k;
        r_end        <= n_end;
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (rs_we)
            r_rs_mem[rs_addr] <= rs_wdata;
        r_rs_q <= r_rs_mem[rs_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cs_we)
            r_cs_mem[cs_addr] <= cs_wdata;
        r_cs_q <= r_cs_mem[cs_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mv_we)
            r_mv_mem[mv_addr] <= mv_wdata;
        r_mv_q <= r_mv_mem[mv_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rh_we)
            r_rh_mem[rh_addr] <= rh_wdata;
        r_rh_q <= r_rh_mem[rh_addr];
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= NZ_FULL)
        else $error("filled entries beyond capacity");

    a_seg_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg <= r_filled)
        else $error("open segment starts past the filled entries");

    a_rows_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        16'(r_rows) <= 16'(lim))
        else $error("more rows built than in use");

    a_take_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> (r_state == S_DEC))
        else $error("accepted request not decoded");
`endif

endmodule

`default_nettype wire
